>>> rtl/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Shared sizes, the lane control bundle and mask width helpers for the
// button edge and auto-repeat block.
// ----------------------------------------------------------------------------
package bae_pkg;

    localparam int NUM_BUTTONS = 12;
    localparam int COUNT_WIDTH = 16;
    localparam int TIMING_W    = 16;
    localparam int MASK_W      = 12;
    localparam int ID_W        = 4;
    localparam int WIDE_W      = (COUNT_WIDTH > TIMING_W) ? COUNT_WIDTH : TIMING_W;
    localparam int DIV_W       = TIMING_W + 1;
    localparam int STEP_W      = $clog2(COUNT_WIDTH + 1);
    localparam int DATA_W      = 4 * MASK_W;

    // Broadcast from the sequencer to every lane.
    typedef struct packed {
        logic                frame_start;
        logic                step;
        logic [TIMING_W-1:0] start_frames;
        logic [TIMING_W-1:0] repeat_frames;
    } bae_lane_ctrl_t;

    // Button vector to the fixed 12-bit field: zero-extend or keep the low bits.
    function automatic logic [MASK_W-1:0] to_mask(input logic [NUM_BUTTONS-1:0] v);
        logic [MASK_W+NUM_BUTTONS-1:0] tmp;
        tmp = (MASK_W + NUM_BUTTONS)'(v);
        return tmp[MASK_W-1:0];
    endfunction

    // Fixed 12-bit field to the button vector.
    function automatic logic [NUM_BUTTONS-1:0] from_mask(input logic [MASK_W-1:0] v);
        logic [MASK_W+NUM_BUTTONS-1:0] tmp;
        tmp = (MASK_W + NUM_BUTTONS)'(v);
        return tmp[NUM_BUTTONS-1:0];
    endfunction

endpackage

>>> rtl/bae_lane.sv
// ----------------------------------------------------------------------------
// bae_lane
// One button: hold counter, repeat timing and a bit-serial restoring
// remainder unit that decides the repeat trigger.
// ----------------------------------------------------------------------------
module bae_lane import bae_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  bae_lane_ctrl_t ctrl,
    input  logic           wr_en,
    input  logic           held,
    output logic           trig
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [TIMING_W-1:0]    start_reg;
    logic [TIMING_W-1:0]    period_reg;
    logic [COUNT_WIDTH-1:0] quo_reg, quo_next;
    logic [TIMING_W-1:0]    rem_reg, rem_next;
    logic                   first_reg;
    logic                   rep_ok_reg;

    logic                   adv;
    logic [WIDE_W-1:0]      t_wide;
    logic [WIDE_W-1:0]      s_wide;
    logic [WIDE_W-1:0]      diff;
    logic [DIV_W-1:0]       divisor;
    logic [DIV_W-1:0]       trial;
    logic [DIV_W-1:0]       sub;

    always_comb begin
        adv        = held && (count_reg != COUNT_MAX);
        count_next = held ? (adv ? count_reg + 1'b1 : count_reg) : '0;
        t_wide     = WIDE_W'(count_next);
        s_wide     = WIDE_W'(start_reg);
        diff       = t_wide - s_wide;
        divisor    = {1'b0, period_reg} + DIV_W'(1);
        // The remainder stays below the divisor, so it fits in TIMING_W bits.
        trial      = {rem_reg, quo_reg[COUNT_WIDTH-1]};
        sub        = trial - divisor;
        rem_next   = (trial >= divisor) ? sub[TIMING_W-1:0] : trial[TIMING_W-1:0];
        quo_next   = quo_reg << 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            start_reg  <= '0;
            period_reg <= '0;
            first_reg  <= 1'b0;
            rep_ok_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                start_reg  <= ctrl.start_frames;
                period_reg <= ctrl.repeat_frames;
            end
            if (ctrl.frame_start) begin
                count_reg  <= count_next;
                first_reg  <= (count_next == COUNT_WIDTH'(1));
                rep_ok_reg <= adv && (period_reg != '0) && (t_wide > s_wide);
            end
        end
    end

    // Dividend and remainder carry no reset; they are loaded at every frame.
    always_ff @(posedge aclk) begin
        if (ctrl.frame_start) begin
            quo_reg <= diff[COUNT_WIDTH-1:0];
            rem_reg <= '0;
        end else if (ctrl.step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign trig = first_reg || (rep_ok_reg && (rem_reg == '0));

endmodule

>>> rtl/bae_merge.sv
// ----------------------------------------------------------------------------
// bae_merge
// Combines the lane triggers with the edge masks into one result and holds
// it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module bae_merge import bae_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic [NUM_BUTTONS-1:0] cur,
    input  logic [NUM_BUTTONS-1:0] prev,
    input  logic [NUM_BUTTONS-1:0] trig,
    output logic                   free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DATA_W-1:0]      m_tdata
);

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next;

    always_comb begin
        free       = !valid_reg || m_tready;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = {to_mask(trig), to_mask(prev & ~cur),
                          to_mask(cur & ~prev), to_mask(cur)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> rtl/button_edge_and_auto_repeat.sv
// ----------------------------------------------------------------------------
// button_edge_and_auto_repeat
// Per-frame button edge detection with per-button auto-repeat triggers.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one transaction per item. With s_tuser low the
// item is a frame update whose s_tdata carries the held-button mask; with
// s_tuser high it sets the repeat start delay and period of one button and
// produces no result. Each frame update produces one master transaction
// with the held, pressed, released and trigger masks.
// Every button has its own lane with a hold counter and a bit-serial
// remainder unit; all lanes run at once. The remainder takes one
// dividend bit per cycle over the COUNT_WIDTH dividend bits; once it is
// done and the output register is free, the frame result is loaded into
// that register, which drives m_tvalid, and only then is the next item accepted.
// A set-repeat transaction leaves the block idle and ready for the next
// item.
// The result sits in an output register: while the receiver stalls, the
// block still accepts and works on the next item, and only holds that
// item's result until the register frees up.
// Reset (aresetn low, synchronous) clears all hold counters, timing
// settings (repeat disabled) and the remembered button masks.
// ----------------------------------------------------------------------------
module button_edge_and_auto_repeat import bae_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // s_tdata: button_mask[11:0], button_id[15:12], start_frames[31:16],
    //          repeat_frames[47:32]
    input  logic [47:0]       s_tdata,
    // s_tuser: cmd[0] (0 = frame update, 1 = set repeat timing)
    input  logic [0:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // m_tdata: held_mask[11:0], pressed_mask[23:12], released_mask[35:24],
    //          trigger_mask[47:36]
    output logic [DATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [NUM_BUTTONS-1:0] cur_reg, cur_next;
    logic [NUM_BUTTONS-1:0] prev_reg, prev_next;

    logic                   accept;
    logic                   is_frame;
    logic                   is_timing;
    logic                   load;
    logic                   out_free;
    logic [NUM_BUTTONS-1:0] wr_sel;
    logic [NUM_BUTTONS-1:0] trig;
    logic [ID_W-1:0]        button_id;
    bae_lane_ctrl_t         lane_ctrl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_frame  = accept && !s_tuser[0];
    assign is_timing = accept && s_tuser[0];
    assign button_id = s_tdata[15:12];
    assign load      = (state_reg == ST_DONE) && out_free;

    // A set-repeat transaction with an id beyond the last button selects no lane.
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            wr_sel[i] = is_timing && (32'(button_id) == 32'(i));
        end
    end

    always_comb begin
        lane_ctrl.frame_start   = is_frame;
        lane_ctrl.step          = (state_reg == ST_RUN);
        lane_ctrl.start_frames  = s_tdata[31:16];
        lane_ctrl.repeat_frames = s_tdata[47:32];
    end

    // Sequencer: one frame start, COUNT_WIDTH remainder steps, then hand-off.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        case (state_reg)
            ST_IDLE: begin
                if (is_frame) begin
                    prev_next  = cur_reg;
                    cur_next   = from_mask(s_tdata[MASK_W-1:0]);
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(COUNT_WIDTH - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cur_reg   <= '0;
            prev_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cur_reg   <= cur_next;
            prev_reg  <= prev_next;
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bae_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .wr_en   (wr_sel[g]),
            .held    (cur_next[g]),
            .trig    (trig[g])
        );
    end

    bae_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .cur      (cur_reg),
        .prev     (prev_reg),
        .trig     (trig),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A frame transaction always starts the remainder sequence.
    a_frame_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        is_frame |=> (state_reg == ST_RUN))
        else $error("frame transaction did not start the lanes");

    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending transaction");

    // A button can only trigger while it is held.
    a_trig_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[47:36] & ~m_tdata[11:0]) == '0))
        else $error("trigger on a button that is not held");

    // Pressed buttons are held, and no button is both pressed and released.
    a_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (((m_tdata[23:12] & ~m_tdata[11:0]) == '0)
                      && ((m_tdata[23:12] & m_tdata[35:24]) == '0)))
        else $error("inconsistent edge masks");

endmodule
